// ----- rtl/cht_pkg.sv -----
`timescale 1ns / 1ps

package cht_pkg;

	// Sizes
	localparam int BUCKET_COUNT = 64;
	localparam int POOL_DEPTH   = 64;
	localparam int KEY_WIDTH    = 32;
	localparam int IDX_W        = $clog2(POOL_DEPTH);
	localparam int LINK_W       = IDX_W + 1;
	localparam int BKT_W        = $clog2(BUCKET_COUNT);
	localparam int CNT_W        = $clog2(POOL_DEPTH + 1);
	localparam int LOG2_W       = 3;
	localparam int MAX_LOG2     = 6;
	localparam int RESET_LOG2   = 3;

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [LINK_W-1:0]    link_t;
	typedef logic [BKT_W-1:0]     bkt_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [LOG2_W-1:0]    log2_t;
	typedef logic [1:0]           code_t;

	// "no entry" marker for heads and links
	localparam link_t NONE_LINK = LINK_W'(POOL_DEPTH);

	// request types
	localparam code_t REQ_LOOKUP = 2'd0;
	localparam code_t REQ_INSERT = 2'd1;
	localparam code_t REQ_REMOVE = 2'd2;

	// result status
	localparam code_t ST_OK   = 2'd0;
	localparam code_t ST_MISS = 2'd1;
	localparam code_t ST_FULL = 2'd2;

	typedef struct packed {
		logic  head_we;
		bkt_t  head_waddr;
		link_t head_wdata;
		bkt_t  head_raddr;
		logic  link_we;
		idx_t  link_waddr;
		link_t link_wdata;
		idx_t  link_raddr;
	} link_cmd_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		key_t wdata;
		idx_t raddr;
	} key_cmd_t;

endpackage

// ----- rtl/cht_link_mem.sv -----
`timescale 1ns / 1ps

// Bucket heads and entry links. Valid bits supply the reset contents:
// an unwritten head reads as empty, an unwritten link as the next entry.
module cht_link_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  cht_pkg::link_cmd_t cmd,
	output cht_pkg::link_t    head_rd,
	output cht_pkg::link_t    link_rd
);
	import cht_pkg::*;

	link_t head_mem [BUCKET_COUNT];
	link_t link_mem [POOL_DEPTH];

	logic [BUCKET_COUNT-1:0] head_vld_q;
	logic [POOL_DEPTH-1:0]   link_vld_q;
	link_t head_raw_q;
	link_t link_raw_q;
	logic  head_hit_q;
	logic  link_hit_q;
	idx_t  link_addr_q;

	always_ff @(posedge clk) begin
		if (cmd.head_we) begin
			head_mem[cmd.head_waddr] <= cmd.head_wdata;
		end
		head_raw_q <= head_mem[cmd.head_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.link_we) begin
			link_mem[cmd.link_waddr] <= cmd.link_wdata;
		end
		link_raw_q  <= link_mem[cmd.link_raddr];
		link_addr_q <= cmd.link_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			link_vld_q <= '0;
			head_hit_q <= 1'b0;
			link_hit_q <= 1'b0;
		end else begin
			if (cmd.head_we) begin
				head_vld_q[cmd.head_waddr] <= 1'b1;
			end
			if (cmd.link_we) begin
				link_vld_q[cmd.link_waddr] <= 1'b1;
			end
			head_hit_q <= head_vld_q[cmd.head_raddr];
			link_hit_q <= link_vld_q[cmd.link_raddr];
		end
	end

	assign head_rd = head_hit_q ? head_raw_q : NONE_LINK;
	assign link_rd = link_hit_q ? link_raw_q : (LINK_W'(link_addr_q) + LINK_W'(1));

endmodule

// ----- rtl/cht_key_cmp.sv -----
`timescale 1ns / 1ps

// Entry key store and the shared key comparator.
module cht_key_cmp (
	input  logic             clk,
	input  cht_pkg::key_cmd_t cmd,
	input  cht_pkg::key_t    ref_key,
	output logic             match
);
	import cht_pkg::*;

	key_t key_mem [POOL_DEPTH];
	key_t key_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			key_mem[cmd.waddr] <= cmd.wdata;
		end
		key_rd_q <= key_mem[cmd.raddr];
	end

	assign match = (key_rd_q == ref_key);

endmodule

// ----- rtl/cht_seq.sv -----
`timescale 1ns / 1ps

// Request sequencer: insert, chain walk, unlink, free list and entry count.
module cht_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cht_pkg::code_t     req_type,
	input  cht_pkg::key_t      key,
	input  cht_pkg::log2_t     log2_cfg,
	input  cht_pkg::link_t     head_rd,
	input  cht_pkg::link_t     link_rd,
	input  logic               match,
	output cht_pkg::link_cmd_t lcmd,
	output cht_pkg::key_cmd_t  kcmd,
	output cht_pkg::key_t      key_hold,
	output logic               busy,
	output logic               done,
	output cht_pkg::code_t     status,
	output cht_pkg::idx_t      entry_index,
	output cht_pkg::cnt_t      entries_held
);
	import cht_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_HEAD = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_REM  = 3'd4;

	logic [2:0] state_q;
	logic       is_rem_q;
	key_t       key_q;
	bkt_t       bkt_q;
	link_t      cur_q;
	link_t      prev_q;
	idx_t       steps_q;
	link_t      free_head_q;
	cnt_t       count_q;
	logic       done_q;
	code_t      status_q;
	idx_t       index_q;

	log2_t lg;
	bkt_t  bkt_in;
	idx_t  rd_addr;

	// bucket = key masked to lg low bits, lg saturated at MAX_LOG2
	always_comb begin
		lg = (log2_cfg > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : log2_cfg;
		for (int i = 0; i < BKT_W; i++) begin
			bkt_in[i] = key[i] & (i < int'(lg));
		end
	end

	always_comb begin
		rd_addr = free_head_q[IDX_W-1:0];
		case (state_q)
			S_HEAD: rd_addr = head_rd[IDX_W-1:0];
			S_CMP:  rd_addr = link_rd[IDX_W-1:0];
			default: begin
			end
		endcase

		lcmd = '0;
		kcmd = '0;
		lcmd.head_raddr = (state_q == S_IDLE) ? bkt_in : bkt_q;
		lcmd.link_raddr = rd_addr;
		kcmd.raddr      = rd_addr;

		case (state_q)
			S_INS: begin
				kcmd.we         = 1'b1;
				kcmd.waddr      = cur_q[IDX_W-1:0];
				kcmd.wdata      = key_q;
				lcmd.link_we    = 1'b1;
				lcmd.link_waddr = cur_q[IDX_W-1:0];
				lcmd.link_wdata = head_rd;
				lcmd.head_we    = 1'b1;
				lcmd.head_waddr = bkt_q;
				lcmd.head_wdata = cur_q;
			end
			S_CMP: begin
				if (match && is_rem_q) begin
					if (prev_q == NONE_LINK) begin
						lcmd.head_we    = 1'b1;
						lcmd.head_waddr = bkt_q;
						lcmd.head_wdata = link_rd;
					end else begin
						lcmd.link_we    = 1'b1;
						lcmd.link_waddr = prev_q[IDX_W-1:0];
						lcmd.link_wdata = link_rd;
					end
				end
			end
			S_REM: begin
				lcmd.link_we    = 1'b1;
				lcmd.link_waddr = cur_q[IDX_W-1:0];
				lcmd.link_wdata = free_head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			key_q    <= key;
			bkt_q    <= bkt_in;
			is_rem_q <= (req_type == REQ_REMOVE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= NONE_LINK;
			prev_q      <= NONE_LINK;
			steps_q     <= '0;
			free_head_q <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			index_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						steps_q <= '0;
						prev_q  <= NONE_LINK;
						case (req_type)
							REQ_INSERT: begin
								if (free_head_q == NONE_LINK) begin
									done_q   <= 1'b1;
									status_q <= ST_FULL;
									index_q  <= '0;
								end else begin
									cur_q   <= free_head_q;
									state_q <= S_INS;
								end
							end
							REQ_LOOKUP, REQ_REMOVE: begin
								state_q <= S_HEAD;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= ST_MISS;
								index_q  <= '0;
							end
						endcase
					end
				end
				S_INS: begin
					free_head_q <= link_rd;
					count_q     <= count_q + CNT_W'(1);
					done_q      <= 1'b1;
					status_q    <= ST_OK;
					index_q     <= cur_q[IDX_W-1:0];
					state_q     <= S_IDLE;
				end
				S_HEAD: begin
					if (head_rd == NONE_LINK) begin
						done_q   <= 1'b1;
						status_q <= ST_MISS;
						index_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						cur_q   <= head_rd;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (match) begin
						if (is_rem_q) begin
							state_q <= S_REM;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
							index_q  <= cur_q[IDX_W-1:0];
							state_q  <= S_IDLE;
						end
					end else if (link_rd == NONE_LINK ||
							steps_q == IDX_W'(POOL_DEPTH - 1)) begin
						done_q   <= 1'b1;
						status_q <= ST_MISS;
						index_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= link_rd;
						steps_q <= steps_q + IDX_W'(1);
					end
				end
				S_REM: begin
					free_head_q <= cur_q;
					if (count_q != '0) begin
						count_q <= count_q - CNT_W'(1);
					end
					done_q   <= 1'b1;
					status_q <= ST_OK;
					index_q  <= cur_q[IDX_W-1:0];
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign key_hold     = key_q;
	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign entry_index  = index_q;
	assign entries_held = count_q;

`ifndef SYNTHESIS
	// results only come out once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while busy");

	// free list empty exactly when the pool is fully used
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == NONE_LINK) == (count_q == CNT_W'(POOL_DEPTH)))
		else $error("free list and entry count disagree");

	// the walk only visits real entries
	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP || state_q == S_REM || state_q == S_INS) |-> !cur_q[LINK_W-1])
		else $error("chain walk on a none link");

	// a lookup hit is reported as done with status OK
	a_hit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && match && !is_rem_q) |=> (done_q && status_q == ST_OK))
		else $error("lookup hit not reported");
`endif

endmodule

// ----- rtl/chained_hash_table.sv -----
`timescale 1ns / 1ps

// Chained hash table over a fixed pool of 64 entries.
//
// Request channel: drive req_type and key and raise start; the request is
// taken at a clock edge where start is high and busy is low. busy stays
// high until the request has finished. req_type: lookup, insert, remove;
// the spare code is a no-op that reports not found.
// Result: done pulses for one cycle with status, entry_index (handle into
// the external value store) and entries_held. The receiver cannot stall;
// it must take the result in that cycle.
// Config: cfg_data (log2 of the bucket count, saturated at 6) is written on
// cfg_valid; cfg_ready is always high. Write it only while idle. No rehash.
// Insert writes key, link and bucket head in its own state; a full table
// or the no-op answers from idle; lookup and remove read the bucket head,
// then visit chain entries one per cycle through the key comparator and
// link memory read port; remove adds a state that returns the entry to
// the free list. A new request may be taken in the done cycle.
// Reset: all buckets empty, free list 0..63 in order, count zero, 8
// buckets; no clearing pass, valid bits give the reset contents at once.
module chained_hash_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cht_pkg::code_t      req_type,
	input  cht_pkg::key_t       key,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cht_pkg::log2_t      cfg_data,
	output logic                done,
	output cht_pkg::code_t      status,
	output cht_pkg::idx_t       entry_index,
	output cht_pkg::cnt_t       entries_held
);
	import cht_pkg::*;

	log2_t     bucket_count_log2_q;
	link_cmd_t lcmd;
	key_cmd_t  kcmd;
	link_t     head_rd;
	link_t     link_rd;
	logic      match;
	key_t      key_hold;

	// bucket count register; always ready, host keeps writes to idle time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_log2_q <= LOG2_W'(RESET_LOG2);
		end else if (cfg_valid && cfg_ready) begin
			bucket_count_log2_q <= cfg_data;
		end
	end

	// sequencer owns free list, count and result register
	cht_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.key          (key),
		.log2_cfg     (bucket_count_log2_q),
		.head_rd      (head_rd),
		.link_rd      (link_rd),
		.match        (match),
		.lcmd         (lcmd),
		.kcmd         (kcmd),
		.key_hold     (key_hold),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.entry_index  (entry_index),
		.entries_held (entries_held)
	);

	// bucket head and link memories, one read and one write port each
	cht_link_mem u_link_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (lcmd),
		.head_rd (head_rd),
		.link_rd (link_rd)
	);

	// key memory; compares the fetched entry against the held request key
	cht_key_cmp u_key_cmp (
		.clk     (clk),
		.cmd     (kcmd),
		.ref_key (key_hold),
		.match   (match)
	);

endmodule
